// ===== sv/fpm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and codes of the frame projection block
package fpm_pkg;

    localparam int CFG_W     = 11;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 10;
    localparam int SUM_W     = 18;
    localparam int FSUM_W    = 28;
    localparam int MEAN_W    = 16;
    // widest column or row position over the parameter range (up to 4096)
    localparam int POS_MAX_W = 12;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd160;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd120;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // one classified item on its way to the processing side
    typedef struct packed {
        logic                 is_read;
        logic                 in_range;
        logic                 first_row;
        logic                 row_end;
        logic                 frame_end;
        logic [PIX_W-1:0]     pixel;
        logic [POS_MAX_W-1:0] addr;
        logic [IDX_W-1:0]     row_idx;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [FSUM_W-1:0] fsum;
        logic [SUM_W-1:0]  value;
        logic [IDX_W-1:0]  index;
        logic              done;
        logic              kind;
    } result_t;

endpackage

// ===== sv/frame_projection_and_mean.sv =====
`timescale 1ns / 1ps
// Row and column projection of a luminance frame with frame total and 8.8 mean.
// Items enter a 4-entry command queue at up to one per cycle while it is not full;
// the processing side takes each item in two steps (one to read the column store,
// one to write it or load the output register, the latter waiting while the output
// is held) and takes the next item only once the last is done, so bursts up to the
// queue depth are absorbed at full speed. The last row of a frame then passes
// through the width times height product, divider setup, the bit-serial mean
// divider and the load of the output register. The column store is a MAX_WIDTH-entry
// RAM without a clearing pass; the first row of every frame overwrites it, so the
// block accepts items right after reset.
module frame_projection_and_mean #(
    parameter int MAX_WIDTH  = fpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fpm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] pixel_value, [17:8] column_index, [23:18] zero
    input  logic [fpm_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] operation
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [9:0] projection_index, [27:10] projection_value, [55:28] frame_sum,
    // [71:56] mean_fixed
    output logic [fpm_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] projection_kind
    output logic                               m_tuser,
    // frame_done
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [fpm_pkg::CFG_W-1:0] width_cfg_reg, width_cfg_next;
    logic [fpm_pkg::CFG_W-1:0] height_cfg_reg, height_cfg_next;
    logic [WW-1:0]             width_eff;
    logic [HW-1:0]             height_eff;
    logic                      reg_idx;
    logic                      cfg_write;

    fpm_pkg::q_stat_t          q_stat;
    fpm_pkg::cmd_t             push_cmd, head_cmd;
    logic                      push, pop;
    fpm_pkg::result_t          result;

    // register index from the word address, byte offset ignored
    assign reg_idx   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                fpm_pkg::REG_FRAME_WIDTH:  width_cfg_next  = pwdata[fpm_pkg::CFG_W-1:0];
                fpm_pkg::REG_FRAME_HEIGHT: height_cfg_next = pwdata[fpm_pkg::CFG_W-1:0];
                default:                   width_cfg_next  = width_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= fpm_pkg::RESET_FRAME_WIDTH;
            height_cfg_reg <= fpm_pkg::RESET_FRAME_HEIGHT;
        end else begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
        end
    end

    assign prdata = (reg_idx == fpm_pkg::REG_FRAME_HEIGHT)
                  ? fpm_pkg::APB_DATA_W'(height_cfg_reg)
                  : fpm_pkg::APB_DATA_W'(width_cfg_reg);

    // zero acts as one, oversize acts as the maximum
    assign width_eff = (width_cfg_reg == '0) ? WW'(1)
                     : (32'(width_cfg_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                     : WW'(width_cfg_reg);
    assign height_eff = (height_cfg_reg == '0) ? HW'(1)
                      : (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                      : HW'(height_cfg_reg);

    fpm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_pixel   (s_tdata[fpm_pkg::PIX_W-1:0]),
        .in_cidx    (s_tdata[fpm_pkg::PIX_W +: fpm_pkg::IDX_W]),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (push_cmd)
    );

    fpm_queue #(
        .DEPTH (fpm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .pop     (pop),
        .dout    (head_cmd),
        .stat    (q_stat)
    );

    fpm_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW),
        .HW        (HW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .q_cmd      (head_cmd),
        .pop        (pop),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (result)
    );

    assign m_tdata = {result.mean, result.fsum, result.value, result.index};
    assign m_tuser = result.kind;
    assign m_tlast = result.done;

`ifndef NO_ASSERTIONS
    // column reads never end a frame and carry no totals
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpm_pkg::KIND_COLUMN |->
            !m_tlast && m_tdata[fpm_pkg::M_TDATA_W-1:fpm_pkg::IDX_W+fpm_pkg::SUM_W] == '0)
        else $error("column result carries frame totals");

    // a row that does not end the frame has zero total and mean
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpm_pkg::KIND_ROW && !m_tlast |->
            m_tdata[fpm_pkg::M_TDATA_W-1:fpm_pkg::IDX_W+fpm_pkg::SUM_W] == '0)
        else $error("mid-frame row result carries frame totals");

    // nothing is offered in the cycle after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== sv/fpm_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module fpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fpm_queue.sv =====
`timescale 1ns / 1ps
// short command queue between the classifying and processing sides
module fpm_queue #(
    parameter int DEPTH = fpm_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fpm_pkg::cmd_t    din,
    input  logic             pop,
    output fpm_pkg::cmd_t    dout,
    output fpm_pkg::q_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    fpm_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNTW'(DEPTH));

endmodule

// ===== sv/fpm_front.sv =====
`timescale 1ns / 1ps
// input side: takes items, tracks raster position and classifies each item
module fpm_front #(
    parameter int MAX_WIDTH  = fpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fpm_pkg::DEF_MAX_HEIGHT,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_op,
    input  logic [fpm_pkg::PIX_W-1:0]  in_pixel,
    input  logic [fpm_pkg::IDX_W-1:0]  in_cidx,
    input  logic [WW-1:0]              width_eff,
    input  logic [HW-1:0]              height_eff,
    input  fpm_pkg::q_stat_t           q_stat,
    output logic                       push,
    output fpm_pkg::cmd_t              cmd
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic          row_end;
    logic          frame_end;

    // positions may sit past the size after a mid-frame change, hence >=
    assign row_end   = (32'(col_pos_reg) + 32'd1 >= 32'(width_eff));
    assign frame_end = (32'(row_pos_reg) + 32'd1 >= 32'(height_eff));

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb begin
        cmd.is_read   = (in_op == fpm_pkg::OP_READ);
        cmd.in_range  = (32'(in_cidx) < 32'(MAX_WIDTH));
        cmd.first_row = (row_pos_reg == '0);
        cmd.row_end   = row_end;
        cmd.frame_end = frame_end;
        cmd.pixel     = in_pixel;
        cmd.addr      = cmd.is_read ? fpm_pkg::POS_MAX_W'(in_cidx)
                                    : fpm_pkg::POS_MAX_W'(col_pos_reg);
        cmd.row_idx   = fpm_pkg::IDX_W'(row_pos_reg);
    end

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (push && in_op == fpm_pkg::OP_PIXEL) begin
            if (row_end) begin
                col_pos_next = '0;
                row_pos_next = frame_end ? '0 : row_pos_reg + 1'b1;
            end else begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

// ===== sv/fpm_back.sv =====
`timescale 1ns / 1ps
// processing side: column store, row and frame sums, mean divider, output register
module fpm_back #(
    parameter int MAX_WIDTH = fpm_pkg::DEF_MAX_WIDTH,
    parameter int WW        = $clog2(MAX_WIDTH + 1),
    parameter int HW        = $clog2(fpm_pkg::DEF_MAX_HEIGHT + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fpm_pkg::q_stat_t  q_stat,
    input  fpm_pkg::cmd_t     q_cmd,
    output logic              pop,
    input  logic [WW-1:0]     width_eff,
    input  logic [HW-1:0]     height_eff,
    output logic              out_valid,
    input  logic              out_ready,
    output fpm_pkg::result_t  out_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DW    = WW + HW;
    localparam int CMP_W = DW + 8 + fpm_pkg::FSUM_W;
    localparam int CNT_W = $clog2(fpm_pkg::MEAN_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                  state_reg, state_next;
    fpm_pkg::cmd_t               cmd_reg, cmd_next;
    logic [fpm_pkg::SUM_W-1:0]   row_acc_reg, row_acc_next;
    logic [fpm_pkg::FSUM_W-1:0]  frame_acc_reg, frame_acc_next;
    logic                        out_valid_reg, out_valid_next;
    fpm_pkg::result_t            out_reg, out_next;
    logic [fpm_pkg::SUM_W-1:0]   rsum_reg, rsum_next;
    logic [fpm_pkg::IDX_W-1:0]   ridx_reg, ridx_next;
    logic [fpm_pkg::FSUM_W-1:0]  fsum_reg, fsum_next;
    logic [DW-1:0]               d_reg, d_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [fpm_pkg::MEAN_W-1:0]  dvd_reg, dvd_next;
    logic [fpm_pkg::MEAN_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        sat_reg, sat_next;

    logic                        ram_we, ram_re;
    logic [fpm_pkg::SUM_W-1:0]   ram_wdata, ram_rdata;
    logic                        out_free;
    logic                        needs_out;
    logic [fpm_pkg::SUM_W-1:0]   row_sum;
    logic [fpm_pkg::FSUM_W-1:0]  frame_new;
    logic [DW:0]                 rem_sh;
    logic                        q_bit;

    fpm_ram #(
        .WIDTH (fpm_pkg::SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (CW'(cmd_reg.addr)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (CW'(q_cmd.addr)),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign needs_out = cmd_reg.is_read || cmd_reg.row_end;
    assign row_sum   = row_acc_reg + fpm_pkg::SUM_W'(cmd_reg.pixel);
    assign frame_new = frame_acc_reg + fpm_pkg::FSUM_W'(row_sum);
    // first row of a frame overwrites the column store
    assign ram_wdata = cmd_reg.first_row ? fpm_pkg::SUM_W'(cmd_reg.pixel)
                                         : ram_rdata + fpm_pkg::SUM_W'(cmd_reg.pixel);
    assign rem_sh    = {rem_reg, dvd_reg[fpm_pkg::MEAN_W-1]};
    assign q_bit     = (rem_sh >= {1'b0, d_reg});

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_acc_next   = row_acc_reg;
        frame_acc_next = frame_acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        rsum_next      = rsum_reg;
        ridx_next      = ridx_reg;
        fsum_next      = fsum_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        pop            = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    ram_re     = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!needs_out || out_free) begin
                    state_next = S_IDLE;
                    if (cmd_reg.is_read) begin
                        out_valid_next = 1'b1;
                        out_next.kind  = fpm_pkg::KIND_COLUMN;
                        out_next.index = fpm_pkg::IDX_W'(cmd_reg.addr);
                        out_next.value = cmd_reg.in_range ? ram_rdata : '0;
                        out_next.done  = 1'b0;
                        out_next.fsum  = '0;
                        out_next.mean  = '0;
                    end else begin
                        ram_we = 1'b1;
                        if (!cmd_reg.row_end) begin
                            row_acc_next = row_sum;
                        end else begin
                            row_acc_next = '0;
                            if (!cmd_reg.frame_end) begin
                                frame_acc_next = frame_new;
                                out_valid_next = 1'b1;
                                out_next.kind  = fpm_pkg::KIND_ROW;
                                out_next.index = cmd_reg.row_idx;
                                out_next.value = row_sum;
                                out_next.done  = 1'b0;
                                out_next.fsum  = '0;
                                out_next.mean  = '0;
                            end else begin
                                frame_acc_next = '0;
                                fsum_next      = frame_new;
                                rsum_next      = row_sum;
                                ridx_next      = cmd_reg.row_idx;
                                state_next     = S_MUL;
                            end
                        end
                    end
                end
            end
            S_MUL: begin
                d_next     = DW'(width_eff) * DW'(height_eff);
                state_next = S_DINIT;
            end
            S_DINIT: begin
                // quotient above 16 bits exactly when sum >= pixels * 256
                sat_next   = (CMP_W'(fsum_reg) >= CMP_W'({d_reg, 8'h00}));
                rem_next   = DW'(fsum_reg >> 8);
                dvd_next   = {fsum_reg[7:0], 8'h00};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = q_bit ? DW'(rem_sh - {1'b0, d_reg}) : DW'(rem_sh);
                quo_next = {quo_reg[fpm_pkg::MEAN_W-2:0], q_bit};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(fpm_pkg::MEAN_W - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next.kind  = fpm_pkg::KIND_ROW;
                    out_next.index = ridx_reg;
                    out_next.value = rsum_reg;
                    out_next.done  = 1'b1;
                    out_next.fsum  = fsum_reg;
                    out_next.mean  = sat_reg ? '1 : quo_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_acc_reg   <= '0;
            frame_acc_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_acc_reg   <= row_acc_next;
            frame_acc_reg <= frame_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
        rsum_reg <= rsum_next;
        ridx_reg <= ridx_next;
        fsum_reg <= fsum_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== bench/frame_projection_and_mean_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the frame projection block: projection predictor, stimulus, checks
module frame_projection_and_mean_tb;
    import fpm_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    // room for a full queue of items plus the mean divider, with margin
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;

    class projection_tracker;
        bit [CFG_W-1:0]  width_reg  = RESET_FRAME_WIDTH;
        bit [CFG_W-1:0]  height_reg = RESET_FRAME_HEIGHT;
        bit [SUM_W-1:0]  col_sum [MAX_W];
        int unsigned     cols_written;
        bit [SUM_W-1:0]  row_acc;
        bit [FSUM_W-1:0] frame_acc;
        int unsigned     col_pos;
        int unsigned     row_pos;
        result_t         expected_projections[$];
        int              errors;

        function int unsigned clamp_size(bit [CFG_W-1:0] v, int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return 32'(v);
        endfunction

        function void set_size(logic reg_idx, bit [CFG_W-1:0] v);
            if (reg_idx == REG_FRAME_WIDTH) begin
                width_reg = v;
            end else begin
                height_reg = v;
            end
        endfunction

        function void note_item(logic op, bit [PIX_W-1:0] pix, bit [IDX_W-1:0] cidx);
            int unsigned     w;
            int unsigned     h;
            longint unsigned scaled;
            longint unsigned quotient;
            result_t         r;
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_H);
            r = '0;
            if (op == OP_READ) begin
                r.kind  = KIND_COLUMN;
                r.index = cidx;
                r.value = (cidx < MAX_W) ? col_sum[cidx] : '0;
                expected_projections.push_back(r);
                return;
            end
            // first row of a frame overwrites the column store
            if (col_pos < MAX_W) begin
                if (row_pos == 0) begin
                    col_sum[col_pos] = SUM_W'(pix);
                end else begin
                    col_sum[col_pos] = col_sum[col_pos] + SUM_W'(pix);
                end
                if (col_pos + 1 > cols_written) cols_written = col_pos + 1;
            end
            row_acc = row_acc + SUM_W'(pix);
            if (col_pos + 1 < w) begin
                col_pos++;
                return;
            end
            r.kind    = KIND_ROW;
            r.index   = IDX_W'(row_pos);
            r.value   = row_acc;
            frame_acc = frame_acc + FSUM_W'(row_acc);
            row_acc   = '0;
            col_pos   = 0;
            if (row_pos + 1 >= h) begin
                scaled   = 64'(frame_acc);
                scaled   = scaled << 8;
                quotient = scaled / 64'(w * h);
                r.done   = 1'b1;
                r.fsum   = frame_acc;
                r.mean   = (quotient > 64'hFFFF) ? 16'hFFFF : quotient[MEAN_W-1:0];
                frame_acc = '0;
                row_pos   = 0;
            end else begin
                row_pos++;
            end
            expected_projections.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_projection(result_t got);
            result_t want;
            if (expected_projections.size() == 0) begin
                $error("unexpected result transfer: kind %0d index %0d value %0d",
                       got.kind, got.index, got.value);
                errors++;
                return;
            end
            want = expected_projections.pop_front();
            compare_field("projection_kind", 32'(want.kind), 32'(got.kind));
            compare_field("projection_index", 32'(want.index), 32'(got.index));
            compare_field("projection_value", 32'(want.value), 32'(got.value));
            compare_field("frame_done", 32'(want.done), 32'(got.done));
            compare_field("frame_sum", 32'(want.fsum), 32'(got.fsum));
            compare_field("mean_fixed", 32'(want.mean), 32'(got.mean));
        endfunction

        function void report_leftovers();
            if (expected_projections.size() != 0) begin
                $error("%0d expected projections never arrived, oldest kind %0d index %0d",
                       expected_projections.size(), expected_projections[0].kind,
                       expected_projections[0].index);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [7:0] pixel_value, [17:8] column_index, [23:18] zero
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // [0] operation
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [9:0] projection_index, [27:10] projection_value, [55:28] frame_sum,
    // [71:56] mean_fixed
    logic [M_TDATA_W-1:0]  m_tdata;
    // [0] projection_kind
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    projection_tracker tracker;
    bit                steady = 1'b0;
    int unsigned       stall_left = 0;
    result_t           observed;

    always #10 aclk = ~aclk;

    frame_projection_and_mean DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // mostly no gap, some short ones, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [PIX_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // now and then a size outside the legal range
    function automatic bit [CFG_W-1:0] pick_size(int unsigned limit);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CFG_W'($urandom_range(1, limit));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed.kind  = m_tuser;
            observed.done  = m_tlast;
            observed.index = m_tdata[IDX_W-1:0];
            observed.value = m_tdata[IDX_W +: SUM_W];
            observed.fsum  = m_tdata[IDX_W+SUM_W +: FSUM_W];
            observed.mean  = m_tdata[IDX_W+SUM_W+FSUM_W +: MEAN_W];
            tracker.check_projection(observed);
        end
    end

    task automatic send_item(logic op, bit [PIX_W-1:0] pix, bit [IDX_W-1:0] cidx);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-PIX_W-IDX_W){1'b0}}, cidx, pix};
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.note_item(op, pix, cidx);
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // column_index of a pixel transfer is ignored, so it carries noise
    task automatic send_pixel(bit [PIX_W-1:0] pix);
        send_item(OP_PIXEL, pix, IDX_W'($urandom_range(0, 1023)));
    endtask

    // only columns written since reset are read
    task automatic send_read();
        send_item(OP_READ, PIX_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, tracker.cols_written - 1)));
    endtask

    // write, then read back in the following access
    task automatic set_reg(logic reg_idx, bit [CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-CFG_W){1'b0}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        tracker.set_size(reg_idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        tracker.compare_field(reg_idx == REG_FRAME_WIDTH ? "frame_width" : "frame_height",
                              {{(APB_DATA_W-CFG_W){1'b0}}, v}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h);
        set_reg(REG_FRAME_WIDTH, w);
        set_reg(REG_FRAME_HEIGHT, h);
    endtask

    // results drained, then room for items that produce none
    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (tracker.expected_projections.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        tracker = new;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default 160 x 120 frame, read back the second column
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_item(OP_READ, 8'd255, 10'd1);
        settle();

        // column position already past the new width closes the row at once
        set_frame(11'd2, 11'd2);
        repeat (2) begin
            send_pixel(8'd255);
            send_pixel(8'd0);
        end
        send_item(OP_READ, 8'd0, 10'd0);
        settle();

        // zero sizes behave as one: every pixel ends a frame
        set_frame(11'd0, 11'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        settle();

        // shrink mid-frame: row and frame end together and the mean saturates
        set_frame(11'd8, 11'd2);
        repeat (11) send_pixel(8'd255);
        settle();
        set_frame(11'd2, 11'd1);
        send_pixel(8'd255);
        send_item(OP_READ, 8'd0, 10'd7);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            steady = (ph % 3 == 2);
            set_frame(pick_size(20), pick_size(6));
            repeat (110) begin
                if (tracker.cols_written != 0 && $urandom_range(0, 99) < 12) begin
                    send_read();
                end else begin
                    send_pixel(pick_pixel());
                end
            end
        end

        settle();
        tracker.report_leftovers();
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
